// ===== rtl/gcd_pkg.sv =====
// Shared constants, types and the arctangent table for the great-circle distance block.
// No dependencies; the top level imports this package.
package gcd_pkg;

    // Default number of CORDIC iterations in each arctangent or rotation chain.
    localparam int CORDIC_STEPS_DEF = 32;

    // Angles in degree units of 1e-7.
    localparam logic signed [33:0] FULL_TURN    = 34'sd3600000000;
    localparam logic signed [33:0] HALF_TURN    = 34'sd1800000000;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;

    // pi as an unsigned Q4.60 value and the constants derived from it.
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_TO_RAD_C64 =
        (64'd2 * PI_Q60 + 64'd900000000) / 64'd1800000000;
    localparam logic [31:0] DEG_TO_RAD_C = DEG_TO_RAD_C64[31:0];
    localparam logic [63:0] HALF_PI_Q64 = (PI_Q60 + (64'd1 << 30)) >> 31;
    localparam logic [31:0] HALF_PI_Q30 = HALF_PI_Q64[31:0];
    localparam logic [63:0] QUARTER_PI_Q64 = (PI_Q60 + (64'd1 << 31)) >> 32;
    localparam logic [31:0] QUARTER_PI_Q30 = QUARTER_PI_Q64[31:0];

    // CORDIC gain compensation in Q2.30.
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

    localparam logic [22:0] RADIUS_RESET = 23'd6371000;
    localparam logic [24:0] DIST_MAX     = 25'h1FFFFFF;

    // Sine and cosine in Q2.30 with headroom, and CORDIC angle accumulators.
    typedef logic signed [32:0] t_trig;
    typedef logic signed [33:0] t_ang;

    // atan(2^-i) in Q2.30, rounded to nearest.
    function automatic logic [31:0] atan_q30(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:       v = QUARTER_PI_Q30;
            1:       v = 32'd497837829;
            2:       v = 32'd263043837;
            3:       v = 32'd133525159;
            4:       v = 32'd67021687;
            5:       v = 32'd33543516;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194283;
            9:       v = 32'd2097149;
            default: begin
                if (i <= 30) begin
                    v = 32'd1 << (30 - i);
                end else if (i == 31) begin
                    v = 32'd1;
                end else begin
                    v = 32'd0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/great_circle_distance.sv =====
// Fully pipelined great-circle distance between two points on a sphere.
// Depends on gcd_pkg for constants, types and the arctangent table.
//
// Usage:
//   The slave stream carries one pair of points per transaction: first
//   latitude, first longitude, second latitude, second longitude, each in
//   signed units of 1e-7 degree. The master stream returns the distance in
//   whole meters, rounded and saturated to 25 bits. The sphere radius is
//   written through i_cfg_wr_en / i_cfg_wr_data while the block is idle;
//   the block itself does not enforce this, the user must keep to it.
// Throughput and pipeline depth:
//   One transaction is accepted every cycle while the skid entry is empty.
//   The depth is set by the two CORDIC chains (sine/cosine rotation and
//   arctangent vectoring, one iteration per stage) and the 32-stage square
//   root, plus the stages of angle reduction, multiplication and rounding.
// Reset:
//   A synchronous active-low reset empties the pipeline and the output
//   buffer and restores the radius to 6371000 m.
// Back-pressure:
//   An output register and one skid entry follow the pipeline. When the
//   receiver stalls, the next result lands in the skid entry and the whole
//   pipeline then freezes; o_s_axis_tready drops until the skid entry drains.
//   Nothing is lost or repeated.
module great_circle_distance
    import gcd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [22:0]  i_cfg_wr_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [30:0] first_latitude, [62:31] first_longitude,
    // [93:63] second_latitude, [125:94] second_longitude, [127:126] zero
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [24:0] distance_m, [31:25] zero
    output logic [31:0]  o_m_axis_tdata
);

    localparam int PIPE_DEPTH = 49 + 2 * CORDIC_STEPS;
    localparam int RW = 34;
    localparam int VW = 36;
    localparam int SQ_STEPS = 32;

    logic                  en;
    logic                  s_accept;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [22:0]           r_radius;

    // Angle reduction and degree-to-radian conversion.
    logic signed [32:0] r1_ang [3];
    logic signed [33:0] s2_wrap [3];
    logic signed [33:0] s2_fold [3];
    logic [2:0]         s2_flip;
    logic signed [30:0] r2_red [3];
    logic [2:0]         r2_flip;
    logic [61:0]        r3_prod [3];
    logic [2:0]         r3_neg;
    logic [2:0]         r3_flip;
    logic [63:0]        s4_rnd [3];

    // Rotation CORDIC; entry 0 is the stage that feeds the first iteration.
    logic signed [RW-1:0] r_rx [CORDIC_STEPS+1][3];
    logic signed [RW-1:0] r_ry [CORDIC_STEPS+1][3];
    logic signed [RW-1:0] r_rz [CORDIC_STEPS+1][3];
    logic [2:0]           r_rflip [CORDIC_STEPS+1];

    t_trig r_s1, r_c1, r_s2, r_c2, r_sd, r_cd;

    // Products and the spherical terms.
    logic signed [65:0] r_p_c2sd, r_p_c1s2, r_p_s1c2, r_p_s1s2, r_p_c1c2;
    t_trig              r_m1_cd;
    t_trig              r_q_n1, r_q_c1s2, r_q_s1c2, r_q_s1s2, r_q_c1c2, r_m2_cd;
    logic signed [65:0] r_p_tc, r_p_td;
    t_trig              r_m3_n1, r_m3_c1s2, r_m3_s1s2;
    t_trig              r_q_tc, r_q_td, r_m4_n1, r_m4_c1s2, r_m4_s1s2;
    t_ang               r_m5_n1, r_m5_n2, r_m5_den;
    logic [32:0]        r_m6_a1, r_m6_a2;
    t_ang               r_m6_den;
    logic [63:0]        r_m7_sq1, r_m7_sq2;
    t_ang               r_m7_den;

    // Square root, one result bit per stage.
    logic [63:0] r_sv [SQ_STEPS+1];
    logic [63:0] r_sr [SQ_STEPS+1];
    t_ang        r_sden [SQ_STEPS+1];
    logic [32:0] r_num;
    t_ang        r_rnd_den;

    // Vectoring CORDIC for the arctangent.
    logic signed [VW-1:0] r_vx [CORDIC_STEPS+1];
    logic signed [VW-1:0] r_vy [CORDIC_STEPS+1];
    logic signed [VW-1:0] r_vz [CORDIC_STEPS+1];

    logic [55:0] r_dm_prod;
    logic [56:0] s_dr_sum;
    logic [24:0] r_dist;

    logic        r_out_vld, r_skid_vld;
    logic [24:0] r_out_dist, r_skid_dist;
    logic        s_pop;

    // The pipeline moves as one; it only freezes while the skid entry is full.
    assign en              = !r_skid_vld;
    assign o_s_axis_tready = en;
    assign s_accept        = i_s_axis_tvalid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_wr_en) begin
            r_radius <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], s_accept};
        end
    end

    // Stage 1: capture latitudes and the longitude difference.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ang[0] <= 33'(signed'(i_s_axis_tdata[30:0]));
            r1_ang[2] <= 33'(signed'(i_s_axis_tdata[125:94]))
                       - 33'(signed'(i_s_axis_tdata[62:31]));
            r1_ang[1] <= 33'(signed'(i_s_axis_tdata[93:63]));
        end
    end

    // Stage 2: wrap into a half turn either side of zero, then fold into
    // [-90, 90] degrees, remembering that sine and cosine change sign.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (34'(r1_ang[j]) >= HALF_TURN) begin
                s2_wrap[j] = 34'(r1_ang[j]) - FULL_TURN;
            end else if (34'(r1_ang[j]) < -HALF_TURN) begin
                s2_wrap[j] = 34'(r1_ang[j]) + FULL_TURN;
            end else begin
                s2_wrap[j] = 34'(r1_ang[j]);
            end
            if (s2_wrap[j] > QUARTER_TURN) begin
                s2_fold[j] = s2_wrap[j] - HALF_TURN;
                s2_flip[j] = 1'b1;
            end else if (s2_wrap[j] < -QUARTER_TURN) begin
                s2_fold[j] = s2_wrap[j] + HALF_TURN;
                s2_flip[j] = 1'b1;
            end else begin
                s2_fold[j] = s2_wrap[j];
                s2_flip[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r2_red[j] <= s2_fold[j][30:0];
            end
            r2_flip <= s2_flip;
        end
    end

    // Stage 3: magnitude times the degree-to-radian constant.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r3_prod[j] <= (r2_red[j][30] ? 30'(-r2_red[j]) : r2_red[j][29:0])
                            * DEG_TO_RAD_C;
                r3_neg[j]  <= r2_red[j][30];
            end
            r3_flip <= r2_flip;
        end
    end

    // Stage 4: round to Q2.30 radians, restore the sign, seed the rotation.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            s4_rnd[j] = (64'(r3_prod[j]) + (64'd1 << 30)) >> 31;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_rx[0][j] <= RW'(CORDIC_GAIN_Q30);
                r_ry[0][j] <= '0;
                r_rz[0][j] <= r3_neg[j] ? -RW'(s4_rnd[j][30:0]) : RW'(s4_rnd[j][30:0]);
            end
            r_rflip[0] <= r3_flip;
        end
    end

    // Rotation CORDIC: one iteration per stage for all three angles.
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
        localparam logic signed [RW-1:0] ATAN_K = RW'(atan_q30(k));
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int j = 0; j < 3; j++) begin
                    if (!r_rz[k][j][RW-1]) begin
                        r_rx[k+1][j] <= r_rx[k][j] - (r_ry[k][j] >>> k);
                        r_ry[k+1][j] <= r_ry[k][j] + (r_rx[k][j] >>> k);
                        r_rz[k+1][j] <= r_rz[k][j] - ATAN_K;
                    end else begin
                        r_rx[k+1][j] <= r_rx[k][j] + (r_ry[k][j] >>> k);
                        r_ry[k+1][j] <= r_ry[k][j] - (r_rx[k][j] >>> k);
                        r_rz[k+1][j] <= r_rz[k][j] + ATAN_K;
                    end
                end
                r_rflip[k+1] <= r_rflip[k];
            end
        end
    end

    // Undo the fold: a half-turn shift negates both sine and cosine.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= r_rflip[CORDIC_STEPS][0] ? 33'(-r_ry[CORDIC_STEPS][0])
                                             : 33'(r_ry[CORDIC_STEPS][0]);
            r_c1 <= r_rflip[CORDIC_STEPS][0] ? 33'(-r_rx[CORDIC_STEPS][0])
                                             : 33'(r_rx[CORDIC_STEPS][0]);
            r_s2 <= r_rflip[CORDIC_STEPS][1] ? 33'(-r_ry[CORDIC_STEPS][1])
                                             : 33'(r_ry[CORDIC_STEPS][1]);
            r_c2 <= r_rflip[CORDIC_STEPS][1] ? 33'(-r_rx[CORDIC_STEPS][1])
                                             : 33'(r_rx[CORDIC_STEPS][1]);
            r_sd <= r_rflip[CORDIC_STEPS][2] ? 33'(-r_ry[CORDIC_STEPS][2])
                                             : 33'(r_ry[CORDIC_STEPS][2]);
            r_cd <= r_rflip[CORDIC_STEPS][2] ? 33'(-r_rx[CORDIC_STEPS][2])
                                             : 33'(r_rx[CORDIC_STEPS][2]);
        end
    end

    // First products, then rounding to Q2.30 (floor of value plus one half).
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_c2sd <= r_c2 * r_sd;
            r_p_c1s2 <= r_c1 * r_s2;
            r_p_s1c2 <= r_s1 * r_c2;
            r_p_s1s2 <= r_s1 * r_s2;
            r_p_c1c2 <= r_c1 * r_c2;
            r_m1_cd  <= r_cd;

            r_q_n1    <= 33'((r_p_c2sd + 66'sd536870912) >>> 30);
            r_q_c1s2  <= 33'((r_p_c1s2 + 66'sd536870912) >>> 30);
            r_q_s1c2  <= 33'((r_p_s1c2 + 66'sd536870912) >>> 30);
            r_q_s1s2  <= 33'((r_p_s1s2 + 66'sd536870912) >>> 30);
            r_q_c1c2  <= 33'((r_p_c1c2 + 66'sd536870912) >>> 30);
            r_m2_cd   <= r_m1_cd;

            r_p_tc    <= r_q_s1c2 * r_m2_cd;
            r_p_td    <= r_q_c1c2 * r_m2_cd;
            r_m3_n1   <= r_q_n1;
            r_m3_c1s2 <= r_q_c1s2;
            r_m3_s1s2 <= r_q_s1s2;

            r_q_tc    <= 33'((r_p_tc + 66'sd536870912) >>> 30);
            r_q_td    <= 33'((r_p_td + 66'sd536870912) >>> 30);
            r_m4_n1   <= r_m3_n1;
            r_m4_c1s2 <= r_m3_c1s2;
            r_m4_s1s2 <= r_m3_s1s2;

            // Numerator terms and the cosine-law denominator.
            r_m5_n1  <= 34'(r_m4_n1);
            r_m5_n2  <= 34'(r_m4_c1s2) - 34'(r_q_tc);
            r_m5_den <= 34'(r_m4_s1s2) + 34'(r_q_td);

            r_m6_a1  <= r_m5_n1[33] ? 33'(-r_m5_n1) : r_m5_n1[32:0];
            r_m6_a2  <= r_m5_n2[33] ? 33'(-r_m5_n2) : r_m5_n2[32:0];
            r_m6_den <= r_m5_den;

            r_m7_sq1 <= 64'(r_m6_a1 * r_m6_a1);
            r_m7_sq2 <= 64'(r_m6_a2 * r_m6_a2);
            r_m7_den <= r_m6_den;

            r_sv[0]   <= r_m7_sq1 + r_m7_sq2;
            r_sr[0]   <= '0;
            r_sden[0] <= r_m7_den;
        end
    end

    // Digit-by-digit square root of the Q4.60 sum of squares.
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_sv[k] >= r_sr[k] + SQ_BIT) begin
                    r_sv[k+1] <= r_sv[k] - (r_sr[k] + SQ_BIT);
                    r_sr[k+1] <= (r_sr[k] >> 1) + SQ_BIT;
                end else begin
                    r_sv[k+1] <= r_sv[k];
                    r_sr[k+1] <= r_sr[k] >> 1;
                end
                r_sden[k+1] <= r_sden[k];
            end
        end
    end

    // Round the root to nearest, then rotate a negative denominator into the
    // right half plane by a quarter turn before vectoring.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num     <= r_sr[SQ_STEPS][32:0]
                       + 33'(r_sv[SQ_STEPS] > r_sr[SQ_STEPS]);
            r_rnd_den <= r_sden[SQ_STEPS];

            if (r_rnd_den[33]) begin
                r_vx[0] <= VW'(r_num);
                r_vy[0] <= -VW'(r_rnd_den);
                r_vz[0] <= VW'(HALF_PI_Q30);
            end else begin
                r_vx[0] <= VW'(r_rnd_den);
                r_vy[0] <= VW'(r_num);
                r_vz[0] <= '0;
            end
        end
    end

    // Vectoring CORDIC drives y toward zero and accumulates the angle.
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
        localparam logic signed [VW-1:0] ATAN_K = VW'(atan_q30(k));
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_vy[k] > 0) begin
                    r_vx[k+1] <= r_vx[k] + (r_vy[k] >>> k);
                    r_vy[k+1] <= r_vy[k] - (r_vx[k] >>> k);
                    r_vz[k+1] <= r_vz[k] + ATAN_K;
                end else begin
                    r_vx[k+1] <= r_vx[k] - (r_vy[k] >>> k);
                    r_vy[k+1] <= r_vy[k] + (r_vx[k] >>> k);
                    r_vz[k+1] <= r_vz[k] - ATAN_K;
                end
            end
        end
    end

    // Scale the central angle by the radius, round to meters and saturate.
    // A slightly negative angle from rounding counts as zero.
    assign s_dr_sum = 57'(r_dm_prod) + (57'd1 << 29);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dm_prod <= (r_vz[CORDIC_STEPS][VW-1] ? 33'd0 : r_vz[CORDIC_STEPS][32:0])
                       * r_radius;
            r_dist    <= (s_dr_sum[56:55] != 2'b00) ? DIST_MAX : s_dr_sum[54:30];
        end
    end

    // Output register plus one skid entry.
    assign s_pop = r_out_vld && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (s_pop) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[PIPE_DEPTH-1]) begin
            if (!r_out_vld || s_pop) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (s_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (s_pop) begin
                r_out_dist <= r_skid_dist;
            end
        end else if (r_vld[PIPE_DEPTH-1]) begin
            if (!r_out_vld || s_pop) begin
                r_out_dist <= r_dist;
            end else begin
                r_skid_dist <= r_dist;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {7'd0, r_out_dist};

`ifndef ASSERT_OFF
    // A held skid entry always has a result ahead of it in the output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry full while output register empty");

    // An accepted transaction enters the first pipeline stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted transaction missing from first stage");

    // While the receiver stalls, the skid entry keeps its result.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_m_axis_tready) |=> r_skid_vld)
        else $error("skid entry dropped during a stall");

    // The pad bits above the distance stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[31:25] == 7'd0))
        else $error("distance padding not zero");
`endif

endmodule

// ===== tb/sv/tb_great_circle_distance.sv =====
// Self-checking testbench for the great-circle distance block.
// Depends on the RTL in rtl/ (gcd_pkg and great_circle_distance); needs nothing else.
module tb_great_circle_distance;

    timeunit 1ns;
    timeprecision 1ps;

    // Clock, reset and the block's ports.
    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [22:0]  i_cfg_wr_data;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // [30:0] first_latitude, [62:31] first_longitude,
    // [93:63] second_latitude, [125:94] second_longitude, [127:126] zero
    logic [127:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // [24:0] distance_m, [31:25] zero
    logic [31:0]  o_m_axis_tdata;

    great_circle_distance DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Number of CORDIC iterations the block is built with (its default).
    localparam int STEPS = 32;
    // Pipeline depth in cycles, used for the final settling wait.
    localparam int PIPE_DEPTH = 50 + 2 * STEPS;

    localparam longint unsigned PI_Q60_U  = 64'h3243F6A8885A308D;
    localparam longint unsigned RAD_SCALE =
        (64'd2 * PI_Q60_U + 64'd900000000) / 64'd1800000000;
    localparam longint HALF_PI_FX    = longint'((PI_Q60_U + (64'd1 << 30)) >> 31);
    localparam longint QUARTER_PI_FX = longint'((PI_Q60_U + (64'd1 << 31)) >> 32);
    localparam longint GAIN_FX       = 64'sd652032874;
    localparam longint TURN          = 64'sd3600000000;
    localparam longint HALF          = 64'sd1800000000;
    localparam longint QUARTER       = 64'sd900000000;
    localparam longint unsigned DIST_SAT = 64'd33554431;

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Model-side copy of the radius register and the arctangent table.
    logic [22:0]  radius_m;
    longint       atan_tab [STEPS];
    logic [24:0]  distance_q [$];
    bit           failed;
    bit           quiet;   // no idling on either side when set

    // Builds atan(2^-i) in Q2.30 from the alternating arctangent series.
    function automatic void build_atan_table();
        longint unsigned pos, neg, t;
        int unsigned sh;
        atan_tab[0] = QUARTER_PI_FX;
        for (int i = 1; i < STEPS; i++) begin
            pos = 0;
            neg = 0;
            for (int n = 0; ; n++) begin
                sh = i * (2 * n + 1);
                if (sh > 60) break;
                t = ((64'd1 << 60) >> sh) / longint'(2 * n + 1);
                if (n % 2 == 0) pos += t;
                else neg += t;
            end
            atan_tab[i] = longint'(((pos - neg) + (64'd1 << 29)) >> 30);
        end
    endfunction

    // Q2.30 product, rounded to nearest (ties toward plus infinity).
    function automatic longint fx_mul(longint a, longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    // Degree units of 1e-7 (already within a quarter turn) to Q2.30 radians.
    function automatic longint deg_to_rad(longint a);
        longint unsigned m, r;
        m = (a < 0) ? longint'(-a) : longint'(a);
        r = (m * RAD_SCALE + (64'd1 << 30)) >> 31;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    // Rotation-mode CORDIC after folding the angle into [-90, 90] degrees.
    function automatic void rotate(input longint a, output longint s, output longint c);
        longint r, x, y, z, nx, ny;
        bit flip;
        r = a % TURN;
        x = GAIN_FX;
        y = 0;
        flip = 0;
        if (r < 0) r += TURN;
        if (r >= HALF) r -= TURN;
        if (r > QUARTER) begin
            r -= HALF;
            flip = 1;
        end else if (r < -QUARTER) begin
            r += HALF;
            flip = 1;
        end
        z = deg_to_rad(r);
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_tab[i];
            end
            x = nx;
            y = ny;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // Vectoring-mode CORDIC for atan2(num, den); a negative result is clamped to zero.
    function automatic longint central_angle(longint num, longint den);
        longint x, y, z, nx, ny;
        x = den;
        y = num;
        z = 0;
        if (x < 0) begin
            x = num;
            y = -den;
            z = HALF_PI_FX;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += atan_tab[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= atan_tab[i];
            end
            x = nx;
            y = ny;
        end
        return (z < 0) ? 0 : z;
    endfunction

    // Integer square root, rounded to nearest.
    function automatic longint unsigned isqrt_round(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (v > r) r++;
        return r;
    endfunction

    // Expected distance in meters for one coordinate pair at the current radius.
    function automatic logic [24:0] distance_of(logic [30:0] lat1_b, logic [31:0] lon1_b,
                                                logic [30:0] lat2_b, logic [31:0] lon2_b);
        longint lat1, lon1, lat2, lon2;
        longint s1, c1, s2, c2, sd, cd, n1, n2, den, ang;
        longint unsigned num, d;
        lat1 = longint'($signed(lat1_b));
        lon1 = longint'($signed(lon1_b));
        lat2 = longint'($signed(lat2_b));
        lon2 = longint'($signed(lon2_b));
        rotate(lat1, s1, c1);
        rotate(lat2, s2, c2);
        rotate(lon2 - lon1, sd, cd);
        n1  = fx_mul(c2, sd);
        n2  = fx_mul(c1, s2) - fx_mul(fx_mul(s1, c2), cd);
        den = fx_mul(s1, s2) + fx_mul(fx_mul(c1, c2), cd);
        num = isqrt_round(longint'(n1 * n1) + longint'(n2 * n2));
        ang = central_angle(longint'(num), den);
        d = (longint'(ang) * longint'({41'd0, radius_m}) + (64'd1 << 29)) >> 30;
        if (d > DIST_SAT) d = DIST_SAT;
        return d[24:0];
    endfunction

    // Sends one coordinate pair, optionally after an idle burst, and records
    // its expected distance when the transaction is accepted.
    task automatic send_pair(logic [30:0] lat1, logic [31:0] lon1,
                             logic [30:0] lat2, logic [31:0] lon2);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, lon2, lat2, lon1, lat1};
        do @(posedge i_clk); while (!o_s_axis_tready);
        distance_q.push_back(distance_of(lat1, lon1, lat2, lon2));
    endtask

    // Lowers valid and waits until every expected distance has arrived.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (distance_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the radius register; only called while the block is idle.
    task automatic write_radius(logic [22:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        radius_m = value;
        @(posedge i_clk);
    endtask

    function automatic logic [30:0] rand_lat();
        // Mostly true latitudes, sometimes anything the field can hold.
        if ($urandom_range(0, 7) == 0) return 31'($urandom);
        return 31'($urandom_range(0, 1800000000) - 900000000);
    endfunction

    function automatic logic [31:0] rand_lon();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return 32'($urandom_range(0, 3600000000) - 1800000000);
    endfunction

    // Extremes of every field and the special cases of the formula.
    task automatic test_directed();
        send_pair(31'd0, 32'd0, 31'd0, 32'd0);                       // same point
        send_pair(31'd0, 32'd0, 31'd0, 32'd1800000000);              // antipodal on equator
        send_pair(31'd900000000, 32'd0, -31'sd900000000, 32'd0);     // pole to pole
        send_pair(31'd900000000, 32'd12345, 31'd900000000, -32'sd777); // both at north pole
        send_pair(31'd0, -32'sd1800000000, 31'd0, 32'd1800000000);   // dl of a full turn
        send_pair(31'd0, 32'h7FFFFFFF, 31'd0, 32'h80000000);         // longitude field extremes
        send_pair(31'h3FFFFFFF, 32'd0, 31'h40000000, 32'd0);         // latitudes beyond 90 degrees
        send_pair(31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF);
        send_pair(31'h7FFFFFFF, 32'hFFFFFFFF, 31'd1, 32'd1);         // minus one units
        send_pair(31'd515000000, -32'sd1270000, 31'd407000000, -32'sd740000000);
        send_pair(31'd10, 32'd0, -31'sd10, 32'd5);                   // tiny separation
        send_pair(31'd450000000, 32'd900000000, -31'sd450000000, -32'sd900000000);
        send_pair(31'd0, 32'd0, 31'd1, 32'd1800000000);              // near antipodal
        send_pair(-31'sd900000000, 32'd1800000000, 31'd899999999, -32'sd1799999999);
        send_pair(31'd1800000000, 32'd0, 31'd0, 32'd0);              // reads as -34.7 deg
        drain();
    endtask

    // A few pairs at each of several radii, extremes included.
    task automatic test_radius();
        logic [22:0] radii [5];
        radii = '{23'd0, 23'h7FFFFF, 23'd6000000, 23'd7000000, 23'd6371000};
        foreach (radii[k]) begin
            write_radius(radii[k]);
            send_pair(31'd0, 32'd0, 31'd0, 32'd1800000000);
            send_pair(31'd0, 32'd0, 31'd0, 32'd900000000);
            repeat (4) send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
            drain();
        end
    endtask

    // Random pairs at random radii; the last stretch runs with no idling.
    task automatic test_random();
        for (int phase = 0; phase < 6; phase++) begin
            write_radius(23'($urandom_range(6000000, 7000000)));
            if (phase == 5) quiet = 1;
            repeat (220) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Nearby points stress the small-angle end.
                    logic [30:0] la;
                    logic [31:0] lo;
                    la = rand_lat();
                    lo = rand_lon();
                    send_pair(la, lo, la + 31'($urandom_range(0, 2000)) - 31'd1000,
                              lo + 32'($urandom_range(0, 2000)) - 32'd1000);
                end else begin
                    send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
                end
            end
            drain();
        end
    endtask

    // Receiver: random stall bursts unless quiet.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b1;
            stall_left      <= 0;
        end else if (stall_left > 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= (stall_left == 1);
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left      <= $urandom_range(1, 4);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Checks each accepted result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        logic [24:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (distance_q.size() == 0) begin
                $error("distance_m: unexpected result transaction, actual %0d",
                       o_m_axis_tdata[24:0]);
                failed = 1;
            end else begin
                want = distance_q.pop_front();
                if (o_m_axis_tdata[24:0] !== want) begin
                    $error("distance_m: expected %0d, actual %0d", want,
                           o_m_axis_tdata[24:0]);
                    failed = 1;
                end
            end
        end
    end

    initial begin
        failed          = 0;
        quiet           = 0;
        radius_m        = 23'd6371000;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        build_atan_table();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_radius();
        test_random();

        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        if (distance_q.size() != 0) begin
            $error("distance_m: %0d expected results never arrived", distance_q.size());
            failed = 1;
        end
        if (!failed) begin
            $display("tb_great_circle_distance passed");
        end else begin
            $display("tb_great_circle_distance failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5ms;
        $display("tb_great_circle_distance failed");
        $finish;
    end

endmodule
